### hw/rtl/tcr_pkg.sv
// ----------------------------------------------------------------------------
// tcr_pkg: shared types and constants of the corridor resampler
// Item types, register indexes, command and status bundles, fixed-point limits.
// ----------------------------------------------------------------------------
`default_nettype none

package tcr_pkg;

  localparam int unsigned FRAC_BITS = 12;

  // 1e-6 m threshold: l2 * 10^12 < 2^(2*FRAC_BITS) <=> l2 < SKIP_LIM
  localparam logic [63:0] TEN12    = 64'd1000000000000;
  localparam logic [65:0] SKIP_LIM =
    66'(((64'd1 << (2 * FRAC_BITS)) + TEN12 - 64'd1) / TEN12);
  // near vertical: h2 * 10^12 < h2 + z2 <=> h2 * (10^12 - 1) < z2
  localparam logic [39:0] VERT_K   = 40'd999999999999;

  localparam int unsigned SQ_W   = 66;
  localparam int unsigned ROOT_W = 34;
  localparam int unsigned REM_W  = 37;
  localparam int unsigned DIST_W = 40;
  localparam int unsigned NUM_W  = 49;

  localparam logic [5:0] SQRT_STEPS = 6'd33;
  localparam logic [5:0] DIV_STEPS  = 6'd17;

  localparam logic [15:0] HW_RESET   = 16'd7373;
  localparam logic [21:0] STEP_RESET = 22'd4096;

  // configuration register indexes
  localparam logic [1:0] CFG_HALF_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_SAMPLE_STEP = 2'd1;

  // line tags
  localparam logic [1:0] LINE_LEFT   = 2'd0;
  localparam logic [1:0] LINE_RIGHT  = 2'd1;
  localparam logic [1:0] LINE_CENTER = 2'd2;
  localparam logic [1:0] LINE_SUM    = 2'd3;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic               first_pose;
    logic               last_pose;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         line_sel;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               sides_kept;
    logic               status_code;
    logic               run_end;
  } out_item_t;

  typedef enum logic [2:0] {
    MUL_NONE, MUL_XX, MUL_YY, MUL_ZZ, MUL_HWY, MUL_HWX
  } mul_sel_e;

  typedef enum logic [1:0] {
    IT_SQRT_L, IT_SQRT_H, IT_DIV_Y, IT_DIV_X
  } it_sel_e;

  typedef enum logic [2:0] {
    EK_FIRST_L, EK_FIRST_R, EK_FIRST_C, EK_LEFT, EK_RIGHT, EK_CENTER,
    EK_SUM_OK, EK_SUM_BAD
  } emit_kind_e;

  typedef struct packed {
    logic       load_in;
    logic       start_traj;
    mul_sel_e   mul_sel;
    logic       sum_l2;
    logic       it_start;
    it_sel_e    it_sel;
    logic       dist_upd;
    logic       side_take;
    logic       center_take;
    logic       set_vert_ofs;
    logic       set_ofs;
    logic       pc_set2;
    logic       pc_clr;
    logic       prev_upd;
    logic       cp_inc;
    logic       emit;
    emit_kind_e emit_kind;
    logic       flush;
  } cmd_t;

  typedef struct packed {
    logic start_cond;
    logic lp;
    logic skip;
    logic side_hit;
    logic center_hit;
    logic vertical;
    logic pose_one;
    logic cp_low;
    logic it_done;
    logic pend_v;
    logic ob_free;
  } status_t;

endpackage

`default_nettype wire

### hw/rtl/trajectory_corridor_resampler.sv
// ----------------------------------------------------------------------------
// trajectory_corridor_resampler: arc-length resampler of a trajectory
// Turns a pose stream into left, right and centre corridor points plus an
// end summary per trajectory.
// ----------------------------------------------------------------------------
// Usage:
//   Poses enter on in_valid_i / in_stall_o as in_item_t; results leave on
//   out_valid_o / out_stall_i as out_item_t, line_sel tagging each one and
//   run_end set on the last result of a pose. Configuration writes on
//   cfg_valid_i / cfg_ready_o (always ready): index 0 half width, 1 sample
//   step; write only while the block is idle.
//   One pose at a time. A pose that opens a trajectory skips the arithmetic
//   and goes on to a summary when it also closes it. Other poses run three
//   squares and a 33-step square root of the segment length, and when side
//   points are due off the vertical the shared root/divide unit also runs
//   the 33-step horizontal root and two 17-step divisions.
//   Each result is staged one step before the output register so that the
//   last one can be tagged; the final result sits in the output register
//   while the next pose is already taken.
//   A stalled receiver holds the output register and the sequencer waits
//   before each emission. Reset clears the counters, distances and stored
//   first and previous poses, restores register defaults, empties the output.
// ----------------------------------------------------------------------------
`default_nettype none

module trajectory_corridor_resampler (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [21:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire tcr_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output tcr_pkg::out_item_t      out_data_o
);

  tcr_pkg::cmd_t    cmd;
  tcr_pkg::status_t st;

  assign cfg_ready_o = 1'b1;

  tcr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  tcr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .st_o        (st),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

### hw/rtl/tcr_iter.sv
// ----------------------------------------------------------------------------
// tcr_iter: shared iterative square root / divider
// Restoring square root (two radicand bits a cycle) or restoring division
// (one numerator bit a cycle); done pulses in the cycle after the last step.
// ----------------------------------------------------------------------------
`default_nettype none

module tcr_iter (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic                         div_i,
  input  wire logic [tcr_pkg::SQ_W-1:0]     rad_i,
  input  wire logic [tcr_pkg::ROOT_W-1:0]   divisor_i,
  output logic                              done_o,
  output logic [tcr_pkg::ROOT_W-1:0]        root_o
);

  logic                          busy_q, done_q, div_q;
  logic [5:0]                    cnt_q;
  logic [tcr_pkg::REM_W-1:0]     rem_q, rn, trial;
  logic [tcr_pkg::SQ_W-1:0]      src_q;
  logic [tcr_pkg::ROOT_W-1:0]    root_q, dvs_q;
  logic                          ge;

  // one step of the shared recurrence
  always_comb begin
    if (div_q) begin
      rn    = {rem_q[tcr_pkg::REM_W-2:0], src_q[tcr_pkg::SQ_W-1]};
      trial = {3'b000, dvs_q};
    end else begin
      rn    = {rem_q[tcr_pkg::REM_W-3:0], src_q[tcr_pkg::SQ_W-1 -: 2]};
      trial = {1'b0, root_q, 2'b01};
    end
    ge = (rn >= trial);
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == 6'd1);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= div_i ? tcr_pkg::DIV_STEPS : tcr_pkg::SQRT_STEPS;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) busy_q <= 1'b0;
      end
    end
  end

  // datapath; division starts with the top bits already below the divisor
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q  <= div_i;
      dvs_q  <= divisor_i;
      root_q <= '0;
      if (div_i) begin
        rem_q <= {5'b0, rad_i[tcr_pkg::NUM_W-1:17]};
        src_q <= {rad_i[16:0], 49'b0};
      end else begin
        rem_q <= '0;
        src_q <= rad_i;
      end
    end else if (busy_q) begin
      rem_q  <= ge ? (rn - trial) : rn;
      root_q <= {root_q[tcr_pkg::ROOT_W-2:0], ge};
      src_q  <= div_q ? {src_q[tcr_pkg::SQ_W-2:0], 1'b0}
                      : {src_q[tcr_pkg::SQ_W-3:0], 2'b00};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

### hw/rtl/tcr_dp.sv
// ----------------------------------------------------------------------------
// tcr_dp: corridor resampler datapath
// Pose registers, shared multiplier, root/divide unit, arc length
// accumulators, result staging and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tcr_dp (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [21:0]        cfg_data_i,
  input  wire tcr_pkg::in_item_t  in_data_i,
  input  wire tcr_pkg::cmd_t      cmd_i,
  output tcr_pkg::status_t        st_o,
  input  wire logic               out_stall_i,
  output logic                    out_valid_o,
  output tcr_pkg::out_item_t      out_data_o
);

  // configuration
  logic [15:0] hw_q;
  logic [21:0] step_q;

  // trajectory state
  logic signed [31:0] cur_x_q, cur_y_q, cur_z_q;
  logic signed [31:0] prev_x_q, prev_y_q, prev_z_q;
  logic signed [31:0] first_x_q, first_y_q, first_z_q;
  logic               fp_q, lp_q;
  logic [1:0]         pose_cnt_q, side_pts_q, center_pts_q;
  logic [tcr_pkg::DIST_W-1:0] side_dist_q, center_dist_q, side_sum, center_sum;

  // arithmetic
  logic [32:0]               sx, sy, sz, ax, ay, az, mul_a, mul_b;
  logic [tcr_pkg::SQ_W-1:0]  prod, sqx_q, sqy_q, sqz_q, h2_q, l2_q, vprod_q;
  logic                      h2_small_q;
  logic [tcr_pkg::NUM_W-1:0] num_q;
  logic [tcr_pkg::ROOT_W-1:0] len_q, h_q, it_root;
  logic [15:0]               mx_q, my_q;
  logic signed [17:0]        ox_q, oy_q;
  tcr_pkg::it_sel_e          it_sel_q;
  logic [tcr_pkg::SQ_W-1:0]  it_rad;
  logic                      it_done;

  // results
  tcr_pkg::out_item_t res, pend_q, out_q, moved;
  logic               pend_v_q, out_v_q, ob_free, move;

  function automatic logic [tcr_pkg::DIST_W-1:0] dist_add(
    input logic [tcr_pkg::DIST_W-1:0] d, input logic [tcr_pkg::ROOT_W-1:0] l);
    logic [tcr_pkg::DIST_W:0] s;
    s = {1'b0, d} + {7'b0, l};
    return s[tcr_pkg::DIST_W] ? '1 : s[tcr_pkg::DIST_W-1:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v[33:31] == 3'b000 || v[33:31] == 3'b111) return v[31:0];
    return v[33] ? 32'sh80000000 : 32'sh7fffffff;
  endfunction

  // segment and magnitudes
  assign sx = {cur_x_q[31], cur_x_q} - {prev_x_q[31], prev_x_q};
  assign sy = {cur_y_q[31], cur_y_q} - {prev_y_q[31], prev_y_q};
  assign sz = {cur_z_q[31], cur_z_q} - {prev_z_q[31], prev_z_q};
  assign ax = sx[32] ? (33'd0 - sx) : sx;
  assign ay = sy[32] ? (33'd0 - sy) : sy;
  assign az = sz[32] ? (33'd0 - sz) : sz;

  // shared multiplier operands
  always_comb begin
    mul_a = ax;
    mul_b = ax;
    case (cmd_i.mul_sel)
      tcr_pkg::MUL_YY:  begin mul_a = ay; mul_b = ay; end
      tcr_pkg::MUL_ZZ:  begin mul_a = az; mul_b = az; end
      tcr_pkg::MUL_HWY: begin mul_a = {17'b0, hw_q}; mul_b = ay; end
      tcr_pkg::MUL_HWX: begin mul_a = {17'b0, hw_q}; mul_b = ax; end
      default:          begin mul_a = ax; mul_b = ax; end
    endcase
  end
  assign prod = {33'b0, mul_a} * {33'b0, mul_b};

  // root / divide operand select
  always_comb begin
    case (cmd_i.it_sel)
      tcr_pkg::IT_SQRT_L: it_rad = l2_q;
      tcr_pkg::IT_SQRT_H: it_rad = h2_q;
      default:            it_rad = {17'b0, num_q};
    endcase
  end

  tcr_iter u_iter (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.it_start),
    .div_i     (cmd_i.it_sel == tcr_pkg::IT_DIV_Y || cmd_i.it_sel == tcr_pkg::IT_DIV_X),
    .rad_i     (it_rad),
    .divisor_i (h_q),
    .done_o    (it_done),
    .root_o    (it_root)
  );

  assign side_sum   = dist_add(side_dist_q, len_q);
  assign center_sum = dist_add(center_dist_q, len_q);

  // result formation
  always_comb begin
    res = '0;
    case (cmd_i.emit_kind)
      tcr_pkg::EK_FIRST_L, tcr_pkg::EK_FIRST_R, tcr_pkg::EK_FIRST_C: begin
        res.line_sel = (cmd_i.emit_kind == tcr_pkg::EK_FIRST_L) ? tcr_pkg::LINE_LEFT :
                       (cmd_i.emit_kind == tcr_pkg::EK_FIRST_R) ? tcr_pkg::LINE_RIGHT :
                                                                  tcr_pkg::LINE_CENTER;
        res.out_x = first_x_q;
        res.out_y = first_y_q;
        res.out_z = first_z_q;
      end
      tcr_pkg::EK_LEFT: begin
        res.line_sel = tcr_pkg::LINE_LEFT;
        res.out_x = sat32(34'(cur_x_q) + 34'(ox_q));
        res.out_y = sat32(34'(cur_y_q) + 34'(oy_q));
        res.out_z = cur_z_q;
      end
      tcr_pkg::EK_RIGHT: begin
        res.line_sel = tcr_pkg::LINE_RIGHT;
        res.out_x = sat32(34'(cur_x_q) - 34'(ox_q));
        res.out_y = sat32(34'(cur_y_q) - 34'(oy_q));
        res.out_z = cur_z_q;
      end
      tcr_pkg::EK_SUM_OK: begin
        res.line_sel   = tcr_pkg::LINE_SUM;
        res.sides_kept = (side_pts_q == 2'd2);
      end
      tcr_pkg::EK_SUM_BAD: begin
        res.line_sel    = tcr_pkg::LINE_SUM;
        res.status_code = 1'b1;
      end
      default: begin
        res.line_sel = tcr_pkg::LINE_CENTER;
        res.out_x = cur_x_q;
        res.out_y = cur_y_q;
        res.out_z = cur_z_q;
      end
    endcase
  end

  // item handed to the output register, tagged when it closes the pose
  always_comb begin
    moved         = pend_q;
    moved.run_end = cmd_i.flush;
  end

  assign ob_free = !out_v_q || !out_stall_i;
  assign move    = (cmd_i.emit && pend_v_q) || cmd_i.flush;

  // control and trajectory state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_q          <= tcr_pkg::HW_RESET;
      step_q        <= tcr_pkg::STEP_RESET;
      pose_cnt_q    <= '0;
      side_pts_q    <= '0;
      center_pts_q  <= '0;
      side_dist_q   <= '0;
      center_dist_q <= '0;
      prev_x_q      <= '0;
      prev_y_q      <= '0;
      prev_z_q      <= '0;
      first_x_q     <= '0;
      first_y_q     <= '0;
      first_z_q     <= '0;
      pend_v_q      <= 1'b0;
      out_v_q       <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == tcr_pkg::CFG_HALF_WIDTH)  hw_q   <= cfg_data_i[15:0];
        if (cfg_index_i == tcr_pkg::CFG_SAMPLE_STEP) step_q <= cfg_data_i;
      end
      if (cmd_i.start_traj) begin
        first_x_q <= cur_x_q;  first_y_q <= cur_y_q;  first_z_q <= cur_z_q;
        prev_x_q  <= cur_x_q;  prev_y_q  <= cur_y_q;  prev_z_q  <= cur_z_q;
        pose_cnt_q    <= 2'd1;
        side_dist_q   <= '0;
        center_dist_q <= '0;
        side_pts_q    <= 2'd1;
        center_pts_q  <= 2'd1;
      end
      if (cmd_i.prev_upd) begin
        prev_x_q <= cur_x_q;  prev_y_q <= cur_y_q;  prev_z_q <= cur_z_q;
      end
      if (cmd_i.pc_set2) pose_cnt_q <= 2'd2;
      if (cmd_i.pc_clr)  pose_cnt_q <= 2'd0;
      if (cmd_i.dist_upd) begin
        if (!st_o.skip) side_dist_q <= side_sum;
        center_dist_q <= center_sum;
      end
      if (cmd_i.side_take) begin
        side_dist_q <= '0;
        if (side_pts_q != 2'd2) side_pts_q <= side_pts_q + 2'd1;
      end
      if (cmd_i.center_take) begin
        center_dist_q <= '0;
        if (center_pts_q != 2'd2) center_pts_q <= center_pts_q + 2'd1;
      end
      if (cmd_i.cp_inc && center_pts_q != 2'd2) center_pts_q <= center_pts_q + 2'd1;
      // staging: the newest result waits so that the last one can be tagged
      if (cmd_i.emit)       pend_v_q <= 1'b1;
      else if (cmd_i.flush) pend_v_q <= 1'b0;
      out_v_q <= move || (out_v_q && out_stall_i);
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      cur_x_q <= in_data_i.pos_x;
      cur_y_q <= in_data_i.pos_y;
      cur_z_q <= in_data_i.pos_z;
      fp_q    <= in_data_i.first_pose;
      lp_q    <= in_data_i.last_pose;
    end
    case (cmd_i.mul_sel)
      tcr_pkg::MUL_XX:  sqx_q <= prod;
      tcr_pkg::MUL_YY:  sqy_q <= prod;
      tcr_pkg::MUL_ZZ: begin
        sqz_q <= prod;
        h2_q  <= sqx_q + sqy_q;
      end
      tcr_pkg::MUL_HWY, tcr_pkg::MUL_HWX: num_q <= prod[tcr_pkg::NUM_W-1:0];
      default: ;
    endcase
    if (cmd_i.sum_l2) begin
      l2_q       <= h2_q + sqz_q;
      vprod_q    <= {41'b0, h2_q[24:0]} * {26'b0, tcr_pkg::VERT_K};
      h2_small_q <= (h2_q[tcr_pkg::SQ_W-1:25] == '0);
    end
    if (cmd_i.it_start) it_sel_q <= cmd_i.it_sel;
    if (it_done) begin
      case (it_sel_q)
        tcr_pkg::IT_SQRT_L: len_q <= it_root;
        tcr_pkg::IT_SQRT_H: h_q   <= it_root;
        tcr_pkg::IT_DIV_Y:  mx_q  <= it_root[15:0];
        default:            my_q  <= it_root[15:0];
      endcase
    end
    if (cmd_i.set_vert_ofs) begin
      ox_q <= '0;
      oy_q <= $signed({2'b00, hw_q});
    end else if (cmd_i.set_ofs) begin
      ox_q <= sy[32] ? -$signed({2'b00, mx_q}) : $signed({2'b00, mx_q});
      oy_q <= sx[32] ? $signed({2'b00, my_q}) : -$signed({2'b00, my_q});
    end
    if (cmd_i.emit) pend_q <= res;
    if (move) out_q <= moved;
  end

  // status
  always_comb begin
    st_o            = '0;
    st_o.start_cond = fp_q || (pose_cnt_q == 2'd0);
    st_o.lp         = lp_q;
    st_o.skip       = (l2_q < tcr_pkg::SKIP_LIM);
    st_o.side_hit   = (side_dist_q >= {18'b0, step_q});
    st_o.center_hit = (center_dist_q >= {18'b0, step_q});
    st_o.vertical   = h2_small_q && (vprod_q < sqz_q);
    st_o.pose_one   = (pose_cnt_q == 2'd1);
    st_o.cp_low     = (center_pts_q != 2'd2);
    st_o.it_done    = it_done;
    st_o.pend_v     = pend_v_q;
    st_o.ob_free    = ob_free;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

### hw/rtl/tcr_ctrl.sv
// ----------------------------------------------------------------------------
// tcr_ctrl: corridor resampler sequencer
// Walks one pose through squares, roots, divisions and the emission order.
// ----------------------------------------------------------------------------
`default_nettype none

module tcr_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire tcr_pkg::status_t  st_i,
  output tcr_pkg::cmd_t          cmd_o
);

  localparam logic [4:0] S_IDLE = 5'd0,  S_DECIDE = 5'd1,  S_MYY = 5'd2,  S_MZZ = 5'd3;
  localparam logic [4:0] S_SUML = 5'd4,  S_SQL = 5'd5,     S_WL = 5'd6,   S_F0 = 5'd7;
  localparam logic [4:0] S_F1 = 5'd8,    S_F2 = 5'd9,      S_DUPD = 5'd10, S_SCHK = 5'd11;
  localparam logic [4:0] S_SQH = 5'd12,  S_WH = 5'd13,     S_MULY = 5'd14, S_DIVY = 5'd15;
  localparam logic [4:0] S_WDY = 5'd16,  S_MULX = 5'd17,   S_DIVX = 5'd18, S_WDX = 5'd19;
  localparam logic [4:0] S_OFS = 5'd20,  S_EL = 5'd21,     S_ER = 5'd22,  S_CCHK = 5'd23;
  localparam logic [4:0] S_EC = 5'd24,   S_LAST = 5'd25,   S_FB = 5'd26,  S_SUM = 5'd27;
  localparam logic [4:0] S_SUM1 = 5'd28, S_FIN = 5'd29;

  logic [4:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: if (in_valid_i) begin
        cmd_o.load_in = 1'b1;
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (st_i.start_cond) begin
          cmd_o.start_traj = 1'b1;
          state_d = st_i.lp ? S_SUM1 : S_FIN;
        end else begin
          cmd_o.mul_sel = tcr_pkg::MUL_XX;
          state_d = S_MYY;
        end
      end
      S_MYY: begin cmd_o.mul_sel = tcr_pkg::MUL_YY; state_d = S_MZZ; end
      S_MZZ: begin cmd_o.mul_sel = tcr_pkg::MUL_ZZ; state_d = S_SUML; end
      S_SUML: begin cmd_o.sum_l2 = 1'b1; state_d = S_SQL; end
      S_SQL: begin
        cmd_o.it_start = 1'b1;
        cmd_o.it_sel   = tcr_pkg::IT_SQRT_L;
        state_d = S_WL;
      end
      S_WL: if (st_i.it_done) state_d = st_i.pose_one ? S_F0 : S_DUPD;
      // held first pose on all three lines
      S_F0: if (st_i.ob_free) begin
        cmd_o.emit = 1'b1;  cmd_o.emit_kind = tcr_pkg::EK_FIRST_L;  state_d = S_F1;
      end
      S_F1: if (st_i.ob_free) begin
        cmd_o.emit = 1'b1;  cmd_o.emit_kind = tcr_pkg::EK_FIRST_R;  state_d = S_F2;
      end
      S_F2: if (st_i.ob_free) begin
        cmd_o.emit = 1'b1;  cmd_o.emit_kind = tcr_pkg::EK_FIRST_C;
        cmd_o.pc_set2 = 1'b1;
        state_d = S_DUPD;
      end
      S_DUPD: begin cmd_o.dist_upd = 1'b1; state_d = S_SCHK; end
      S_SCHK: begin
        if (!st_i.skip && st_i.side_hit) begin
          cmd_o.side_take = 1'b1;
          if (st_i.vertical) begin
            cmd_o.set_vert_ofs = 1'b1;
            state_d = S_EL;
          end else begin
            state_d = S_SQH;
          end
        end else begin
          state_d = S_CCHK;
        end
      end
      // horizontal length, then |sy| and |sx| scaled by half width over it
      S_SQH: begin
        cmd_o.it_start = 1'b1;  cmd_o.it_sel = tcr_pkg::IT_SQRT_H;  state_d = S_WH;
      end
      S_WH:   if (st_i.it_done) state_d = S_MULY;
      S_MULY: begin cmd_o.mul_sel = tcr_pkg::MUL_HWY; state_d = S_DIVY; end
      S_DIVY: begin
        cmd_o.it_start = 1'b1;  cmd_o.it_sel = tcr_pkg::IT_DIV_Y;  state_d = S_WDY;
      end
      S_WDY:  if (st_i.it_done) state_d = S_MULX;
      S_MULX: begin cmd_o.mul_sel = tcr_pkg::MUL_HWX; state_d = S_DIVX; end
      S_DIVX: begin
        cmd_o.it_start = 1'b1;  cmd_o.it_sel = tcr_pkg::IT_DIV_X;  state_d = S_WDX;
      end
      S_WDX:  if (st_i.it_done) state_d = S_OFS;
      S_OFS:  begin cmd_o.set_ofs = 1'b1; state_d = S_EL; end
      S_EL: if (st_i.ob_free) begin
        cmd_o.emit = 1'b1;  cmd_o.emit_kind = tcr_pkg::EK_LEFT;  state_d = S_ER;
      end
      S_ER: if (st_i.ob_free) begin
        cmd_o.emit = 1'b1;  cmd_o.emit_kind = tcr_pkg::EK_RIGHT;  state_d = S_CCHK;
      end
      S_CCHK: begin
        cmd_o.prev_upd = 1'b1;
        if (st_i.center_hit) begin
          cmd_o.center_take = 1'b1;
          state_d = S_EC;
        end else begin
          state_d = S_LAST;
        end
      end
      S_EC: if (st_i.ob_free) begin
        cmd_o.emit = 1'b1;  cmd_o.emit_kind = tcr_pkg::EK_CENTER;  state_d = S_LAST;
      end
      S_LAST: begin
        if (st_i.lp) state_d = st_i.cp_low ? S_FB : S_SUM;
        else         state_d = S_FIN;
      end
      // centre fallback point keeps the centre line at two points
      S_FB: if (st_i.ob_free) begin
        cmd_o.emit = 1'b1;  cmd_o.emit_kind = tcr_pkg::EK_CENTER;
        cmd_o.cp_inc = 1'b1;
        state_d = S_SUM;
      end
      S_SUM: if (st_i.ob_free) begin
        cmd_o.emit = 1'b1;  cmd_o.emit_kind = tcr_pkg::EK_SUM_OK;
        cmd_o.pc_clr = 1'b1;
        state_d = S_FIN;
      end
      S_SUM1: if (st_i.ob_free) begin
        cmd_o.emit = 1'b1;  cmd_o.emit_kind = tcr_pkg::EK_SUM_BAD;
        cmd_o.pc_clr = 1'b1;
        state_d = S_FIN;
      end
      // hand the staged item over, tagged as the last of this pose
      S_FIN: begin
        if (!st_i.pend_v) begin
          state_d = S_IDLE;
        end else if (st_i.ob_free) begin
          cmd_o.flush = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

`ifndef ASSERT_OFF
  a_move_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.flush || (cmd_o.emit && st_i.pend_v)) |-> st_i.ob_free)
    else $error("result moved into a full output register");
  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !st_i.pend_v)
    else $error("staged result left behind at idle");
  a_start_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start_traj |-> !st_i.pend_v)
    else $error("trajectory restart with a staged result");
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_in |=> (state_q == S_DECIDE) && !st_i.pend_v)
    else $error("pose taken while busy");
`endif

endmodule

`default_nettype wire

### test/tb_trajectory_corridor_resampler.sv
// ----------------------------------------------------------------------------
// tb_trajectory_corridor_resampler: self-checking bench of the resampler
// Drives pose items with random gaps, mirrors the arc-length resampling in a
// scoreboard class and checks every result item field by field, in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_trajectory_corridor_resampler;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 900000;

  // corridor predictor and expected result store
  class corridor_sb;
    logic signed [63:0]  prev_p[3];
    logic signed [63:0]  first_p[3];
    int unsigned         n_poses;
    logic [39:0]         side_acc;
    logic [39:0]         centre_acc;
    int unsigned         side_pts;
    int unsigned         centre_pts;
    logic [15:0]         half_w;
    logic [21:0]         step_len;
    tcr_pkg::out_item_t  pending[$];
    int unsigned         errors;
    int unsigned         n_checked;

    function new();
      for (int i = 0; i < 3; i++) begin
        prev_p[i] = '0;
        first_p[i] = '0;
      end
      n_poses = 0;
      side_acc = '0;
      centre_acc = '0;
      side_pts = 0;
      centre_pts = 0;
      half_w = tcr_pkg::HW_RESET;
      step_len = tcr_pkg::STEP_RESET;
      errors = 0;
      n_checked = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [21:0] val);
      if (idx == tcr_pkg::CFG_HALF_WIDTH) half_w = val[15:0];
      else if (idx == tcr_pkg::CFG_SAMPLE_STEP) step_len = val;
    endfunction

    function logic [63:0] isqrt(logic [127:0] v);
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] mid;
      lo = '0;
      hi = 64'd1 << 35;
      while (hi - lo > 1) begin
        mid = lo + ((hi - lo) >> 1);
        if (v < 128'(mid) * 128'(mid)) hi = mid;
        else lo = mid;
      end
      return lo;
    endfunction

    function logic signed [31:0] clamp32(logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
    endfunction

    function void push(logic [1:0] sel, logic signed [63:0] x, logic signed [63:0] y,
                       logic signed [63:0] z, logic kept, logic stat);
      tcr_pkg::out_item_t r;
      r.line_sel = sel;
      r.out_x = x[31:0];
      r.out_y = y[31:0];
      r.out_z = z[31:0];
      r.sides_kept = kept;
      r.status_code = stat;
      r.run_end = 1'b0;
      pending.insert(pending.size(), r);
    endfunction

    function logic [39:0] acc_add(logic [39:0] d, logic [63:0] len);
      logic [63:0] s;
      s = 64'(d) + len;
      return (s > 64'hff_ffff_ffff) ? 40'hff_ffff_ffff : s[39:0];
    endfunction

    // works out the result items caused by one accepted pose
    function void note_pose(tcr_pkg::in_item_t p);
      logic signed [63:0] cur[3];
      logic signed [63:0] sx, sy, sz, ox, oy;
      logic [63:0] ax, ay, az, len, hl, mx, my;
      logic [127:0] h2, l2;
      logic skip, vert;
      int unsigned start_n;
      start_n = pending.size();
      cur[0] = 64'(p.pos_x);
      cur[1] = 64'(p.pos_y);
      cur[2] = 64'(p.pos_z);
      if (p.first_pose || n_poses == 0) begin
        for (int i = 0; i < 3; i++) begin
          first_p[i] = cur[i];
          prev_p[i] = cur[i];
        end
        n_poses = 1;
        side_acc = '0;
        centre_acc = '0;
        side_pts = 1;
        centre_pts = 1;
      end else begin
        sx = cur[0] - prev_p[0];
        sy = cur[1] - prev_p[1];
        sz = cur[2] - prev_p[2];
        ax = sx < 0 ? -sx : sx;
        ay = sy < 0 ? -sy : sy;
        az = sz < 0 ? -sz : sz;
        h2 = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay);
        l2 = h2 + 128'(az) * 128'(az);
        len = isqrt(l2);
        skip = l2 * 128'd1000000000000 < (128'd1 << (2 * tcr_pkg::FRAC_BITS));
        if (n_poses == 1) begin
          push(tcr_pkg::LINE_LEFT, first_p[0], first_p[1], first_p[2], 1'b0, 1'b0);
          push(tcr_pkg::LINE_RIGHT, first_p[0], first_p[1], first_p[2], 1'b0, 1'b0);
          push(tcr_pkg::LINE_CENTER, first_p[0], first_p[1], first_p[2], 1'b0, 1'b0);
          n_poses = 2;
        end
        if (!skip) begin
          side_acc = acc_add(side_acc, len);
          if (side_acc >= 40'(step_len)) begin
            side_acc = '0;
            ox = '0;
            oy = 64'(half_w);
            vert = h2 * 128'd1000000000000 < l2;
            if (!vert) begin
              hl = isqrt(h2);
              mx = (64'(half_w) * ay) / hl;
              my = (64'(half_w) * ax) / hl;
              ox = sy < 0 ? -$signed(mx) : $signed(mx);
              oy = sx < 0 ? $signed(my) : -$signed(my);
            end
            push(tcr_pkg::LINE_LEFT, clamp32(cur[0] + ox), clamp32(cur[1] + oy), cur[2],
                 1'b0, 1'b0);
            push(tcr_pkg::LINE_RIGHT, clamp32(cur[0] - ox), clamp32(cur[1] - oy), cur[2],
                 1'b0, 1'b0);
            if (side_pts < 2) side_pts++;
          end
        end
        centre_acc = acc_add(centre_acc, len);
        if (centre_acc >= 40'(step_len)) begin
          centre_acc = '0;
          push(tcr_pkg::LINE_CENTER, cur[0], cur[1], cur[2], 1'b0, 1'b0);
          if (centre_pts < 2) centre_pts++;
        end
        for (int i = 0; i < 3; i++) prev_p[i] = cur[i];
      end
      if (p.last_pose) begin
        if (n_poses < 2) begin
          push(tcr_pkg::LINE_SUM, '0, '0, '0, 1'b0, 1'b1);
        end else begin
          if (centre_pts < 2) begin
            push(tcr_pkg::LINE_CENTER, cur[0], cur[1], cur[2], 1'b0, 1'b0);
            centre_pts++;
          end
          push(tcr_pkg::LINE_SUM, '0, '0, '0, side_pts >= 2, 1'b0);
        end
        n_poses = 0;
      end
      if (pending.size() > start_n) pending[pending.size() - 1].run_end = 1'b1;
    endfunction

    // compares one result item with the oldest expectation
    function void check_result(tcr_pkg::out_item_t got);
      tcr_pkg::out_item_t exp_r;
      n_checked++;
      if (pending.size() == 0) begin
        $display("%0t: result exp none got %p", $realtime, got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.line_sel !== exp_r.line_sel) begin
        $display("%0t: line_sel exp %0d got %0d", $realtime, exp_r.line_sel, got.line_sel);
        errors++;
      end
      if (got.out_x !== exp_r.out_x) begin
        $display("%0t: out_x exp %0d got %0d", $realtime, exp_r.out_x, got.out_x);
        errors++;
      end
      if (got.out_y !== exp_r.out_y) begin
        $display("%0t: out_y exp %0d got %0d", $realtime, exp_r.out_y, got.out_y);
        errors++;
      end
      if (got.out_z !== exp_r.out_z) begin
        $display("%0t: out_z exp %0d got %0d", $realtime, exp_r.out_z, got.out_z);
        errors++;
      end
      if (got.sides_kept !== exp_r.sides_kept) begin
        $display("%0t: sides_kept exp %0b got %0b", $realtime, exp_r.sides_kept,
                 got.sides_kept);
        errors++;
      end
      if (got.status_code !== exp_r.status_code) begin
        $display("%0t: status_code exp %0b got %0b", $realtime, exp_r.status_code,
                 got.status_code);
        errors++;
      end
      if (got.run_end !== exp_r.run_end) begin
        $display("%0t: run_end exp %0b got %0b", $realtime, exp_r.run_end, got.run_end);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i;
  logic [21:0]        cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  tcr_pkg::in_item_t  in_data_i;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  tcr_pkg::out_item_t out_data_o;

  corridor_sb  sb;
  int unsigned cycles = 0;
  int unsigned n_sent;
  bit          hold_on = 1'b0;
  bit          quiet_rx;
  event        hold_ev;

  trajectory_corridor_resampler dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .in_data_i, .out_valid_o, .out_stall_i, .out_data_o
  );

  // clock
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // cycle count and timeout
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // long receiver hold-off, counted in cycles here
  initial begin
    forever begin
      @(hold_ev);
      hold_on <= 1'b1;
      repeat (600) @(posedge clk_i);
      hold_on <= 1'b0;
    end
  end

  // receiver: random stalls, held off while hold_on is set, none while quiet_rx is set
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
    if (hold_on) begin
      out_stall_i <= 1'b1;
    end else if (quiet_rx) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 5) < 2);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [21:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  // offers one pose after a drawn gap (none with no_gap) and waits for acceptance; valid stays
  // up afterwards so that the next pose can follow without a gap
  task automatic send_pose(tcr_pkg::in_item_t p, bit no_gap = 1'b0);
    int unsigned gap;
    gap = no_gap ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= p;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_pose(p);
    n_sent++;
  endtask

  // stops offering and waits for every expected result
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() > 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  function automatic tcr_pkg::in_item_t mk(logic signed [31:0] x, logic signed [31:0] y,
                                           logic signed [31:0] z, bit fp, bit lp);
    tcr_pkg::in_item_t p;
    p.pos_x = x;
    p.pos_y = y;
    p.pos_z = z;
    p.first_pose = fp;
    p.last_pose = lp;
    return p;
  endfunction

  // one well-formed trajectory with a random walk of mostly bounded steps and occasional jumps in x
  task automatic random_track(int unsigned n, int unsigned span);
    logic signed [31:0] x, y, z;
    x = $urandom;
    y = $urandom;
    z = $urandom;
    if ($urandom_range(0, 3) != 0) begin
      x = $signed(x) >>> 8;
      y = $signed(y) >>> 8;
      z = $signed(z) >>> 8;
    end
    for (int unsigned i = 0; i < n; i++) begin
      send_pose(mk(x, y, z, i == 0, i == n - 1));
      case ($urandom_range(0, 7))
        0: ;
        1: z = z + $signed($urandom_range(0, 2 * span)) - $signed(span);
        2: x = $urandom;
        default: begin
          x = x + $signed($urandom_range(0, 2 * span)) - $signed(span);
          y = y + $signed($urandom_range(0, 2 * span)) - $signed(span);
          z = z + $signed($urandom_range(0, span / 4));
        end
      endcase
    end
  endtask

  initial begin
    sb = new();
    n_sent = 0;
    quiet_rx = 0;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = tcr_pkg::CFG_HALF_WIDTH;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset settings, extremes, single pose, zero and vertical segments
    send_pose(mk(0, 0, 0, 1'b0, 1'b1));
    send_pose(mk(0, 0, 0, 1'b1, 1'b0));
    send_pose(mk(0, 0, 0, 1'b0, 1'b0));
    send_pose(mk(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1'b0, 1'b0));
    send_pose(mk(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 1'b0, 1'b0));
    send_pose(mk(32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b0, 1'b0));
    send_pose(mk(32'sh7fffff00, 32'sh80000000, 0, 1'b0, 1'b1));
    send_pose(mk(100, 200, 300, 1'b1, 1'b0));
    send_pose(mk(100, 200, 300, 1'b0, 1'b0));
    send_pose(mk(101, 200, 300, 1'b0, 1'b1));
    send_pose(mk(-5000, 7000, 0, 1'b0, 1'b0));
    send_pose(mk(-5000, 7000, 9000, 1'b1, 1'b1));
    send_pose(mk(1, 1, 1, 1'b0, 1'b0));
    send_pose(mk(-8000, -9000, 1, 1'b0, 1'b1));
    drain();

    write_reg(tcr_pkg::CFG_HALF_WIDTH, 22'h00ffff);
    write_reg(tcr_pkg::CFG_SAMPLE_STEP, 22'd0);
    send_pose(mk(0, 0, 0, 1'b1, 1'b0));
    send_pose(mk(0, 0, 0, 1'b0, 1'b0));
    send_pose(mk(0, 0, 32'sh40000000, 1'b0, 1'b0));
    send_pose(mk(32'sh7ffffff0, 0, 32'sh40000000, 1'b0, 1'b0));
    send_pose(mk(32'sh7ffffff0, 12345, 32'sh40000000, 1'b0, 1'b1));
    drain();

    write_reg(tcr_pkg::CFG_HALF_WIDTH, 22'd0);
    write_reg(tcr_pkg::CFG_SAMPLE_STEP, 22'h3fffff);
    send_pose(mk(0, 0, 0, 1'b1, 1'b0));
    send_pose(mk(4096, 0, 0, 1'b0, 1'b0));
    send_pose(mk(32'sh80000000, 32'sh7fffffff, 0, 1'b0, 1'b1));
    drain();

    // random: trajectories under several settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(tcr_pkg::CFG_HALF_WIDTH, 22'(tcr_pkg::HW_RESET));
          write_reg(tcr_pkg::CFG_SAMPLE_STEP, 22'd4096);
        end
        1: begin
          write_reg(tcr_pkg::CFG_HALF_WIDTH, 22'($urandom_range(0, 65535)));
          write_reg(tcr_pkg::CFG_SAMPLE_STEP, 22'($urandom_range(0, 20000)));
        end
        2: begin
          write_reg(tcr_pkg::CFG_HALF_WIDTH, 22'd65535);
          write_reg(tcr_pkg::CFG_SAMPLE_STEP, 22'd1);
        end
        3: begin
          write_reg(tcr_pkg::CFG_HALF_WIDTH, 22'($urandom_range(0, 65535)));
          write_reg(tcr_pkg::CFG_SAMPLE_STEP, 22'($urandom_range(0, 4194303)));
        end
        4: begin
          write_reg(tcr_pkg::CFG_HALF_WIDTH, 22'd1);
          write_reg(tcr_pkg::CFG_SAMPLE_STEP, 22'd4194303);
        end
        default: begin
          write_reg(tcr_pkg::CFG_HALF_WIDTH, 22'($urandom_range(0, 65535)));
          write_reg(tcr_pkg::CFG_SAMPLE_STEP, 22'($urandom_range(1000, 9000)));
        end
      endcase
      quiet_rx = (ph == 5);
      while (n_sent < 30 + 55 * (ph + 1)) begin
        if ($urandom_range(0, 9) == 0) begin
          // noise: a stray pose with random flags
          send_pose(mk($urandom, $urandom, $urandom, 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1))));
        end else begin
          random_track($urandom_range(1, 9), (ph == 4) ? 32'h7fffffff : 20000);
        end
      end
      if (ph == 2) begin
        // long receiver hold-off while poses keep coming back to back
        -> hold_ev;
        for (int i = 0; i < 10; i++) send_pose(mk($urandom_range(0, 90000), i * 9000, 0,
                                                 i == 0, i == 9), 1'b1);
      end
      drain();
    end

    $display("Sent %0d poses over directed and random trajectories, six settings;",
             n_sent);
    $display("checked %0d result items including long output back-pressure.",
             sb.n_checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
hw/rtl/tcr_pkg.sv
hw/rtl/tcr_iter.sv
hw/rtl/tcr_dp.sv
hw/rtl/tcr_ctrl.sv
hw/rtl/trajectory_corridor_resampler.sv
test/tb_trajectory_corridor_resampler.sv
